@@ src/skf_pkg.sv @@
package skf_pkg;

  // bank size and fixed-point format
  localparam int CHANNELS  = 5;
  localparam int FRAC_BITS = 16;

  // field widths
  localparam int CH_W     = 3;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EST_W    = 32;
  localparam int VAR_W    = 31;
  localparam int SUM_W    = VAR_W + 1;
  localparam int DIFF_W   = EST_W + 1;
  localparam int GAIN_W   = FRAC_BITS;
  localparam int CNT_W    = $clog2(GAIN_W);
  localparam int PE_W     = GAIN_W + 1 + DIFF_W;
  localparam int PP_W     = GAIN_W + 1 + VAR_W;

  // input queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // reset values, saturated to the positive range
  localparam longint unsigned ONE_FX  = 64'd1 << FRAC_BITS;
  localparam longint unsigned POS_MAX = 64'h7FFF_FFFF;
  localparam longint unsigned EST_FX  = 64'd250 * ONE_FX;
  localparam longint unsigned Q_FX    = (ONE_FX + 64'd5) / 64'd10;
  localparam longint unsigned R_FX    = ONE_FX >> 1;

  localparam logic [EST_W-1:0] EST_RESET = EST_W'((EST_FX > POS_MAX) ? POS_MAX : EST_FX);
  localparam logic [VAR_W-1:0] VAR_RESET = VAR_W'((ONE_FX > POS_MAX) ? POS_MAX : ONE_FX);
  localparam logic [VAR_W-1:0] Q_RESET   = VAR_W'((Q_FX > POS_MAX) ? POS_MAX : Q_FX);
  localparam logic [VAR_W-1:0] R_RESET   = VAR_W'((R_FX > POS_MAX) ? POS_MAX : R_FX);

  // command codes
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_SET     = 1'b1;

  typedef struct packed {
    logic                    command;
    logic [CH_W-1:0]         channel;
    logic signed [EST_W-1:0] measurement;
    logic [VAR_W-1:0]        process_noise;
    logic [VAR_W-1:0]        measurement_noise;
  } skf_in_t;

  typedef struct packed {
    logic signed [EST_W-1:0] estimate;
    logic [CH_W-1:0]         channel_echo;
    logic                    passed_through;
  } skf_out_t;

  typedef enum logic [1:0] {
    OP_MEASURE,
    OP_SET,
    OP_PASS
  } skf_op_t;

  typedef struct packed {
    skf_op_t                 op;
    logic [CH_W-1:0]         channel;
    logic signed [EST_W-1:0] measurement;
    logic [VAR_W-1:0]        process_noise;
    logic [VAR_W-1:0]        measurement_noise;
  } skf_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } skf_state_t;

endpackage

@@ src/scalar_kalman_filter_bank_top.sv @@
// sequence: a measurement goes through the exec, divide, multiply, update and done states,
//   skipping the divide when the channel's measurement noise is zero; a set or passthrough
//   goes from exec to done; the gain comes from the 16-step serial divider, and the back
//   handles one transaction at a time; a 2-entry queue and result register decouple
// reset: synchronous active-low rst_n restores every channel's estimate, variance
//   and noise values and empties the queue and the result register
module scalar_kalman_filter_bank_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  skf_pkg::skf_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output skf_pkg::skf_out_t out_data
);
  import skf_pkg::*;

  logic     q_push;
  logic     q_full;
  skf_cmd_t q_wr_data;
  logic     q_pop;
  logic     q_empty;
  skf_cmd_t q_rd_data;

  // front: accept and classify
  skf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_data  (q_wr_data)
  );

  // queue between front and back
  skf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  // back: filter update and result register
  skf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rd_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

@@ src/skf_front.sv @@
module skf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  skf_pkg::skf_in_t  in_data,
  output logic              q_push,
  input  logic              q_full,
  output skf_pkg::skf_cmd_t q_data
);
  import skf_pkg::*;

  logic     hold_valid_r;
  skf_cmd_t hold_r;
  skf_cmd_t cmd_nxt;
  logic     accept;

  // handshake: the holding register frees as soon as the queue takes it
  assign q_push  = hold_valid_r && !q_full;
  assign in_full = hold_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_data  = hold_r;

  // classify the incoming transaction
  always_comb begin
    cmd_nxt.channel           = in_data.channel;
    cmd_nxt.measurement       = in_data.measurement;
    cmd_nxt.process_noise     = in_data.process_noise;
    cmd_nxt.measurement_noise = in_data.measurement_noise;
    priority if ({1'b0, in_data.channel} >= (CH_W + 1)'(CHANNELS)) begin
      cmd_nxt.op = OP_PASS;
    end else if (in_data.command == CMD_SET) begin
      cmd_nxt.op = OP_SET;
    end else begin
      cmd_nxt.op = OP_MEASURE;
    end
  end

  // holding register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept) begin
      hold_valid_r <= 1'b1;
    end else if (q_push) begin
      hold_valid_r <= 1'b0;
    end
  end

  // holding register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= cmd_nxt;
    end
  end

endmodule

@@ src/skf_queue.sv @@
module skf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  skf_pkg::skf_cmd_t wr_data,
  input  logic              pop,
  output logic              empty,
  output skf_pkg::skf_cmd_t rd_data
);
  import skf_pkg::*;

  skf_cmd_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entry_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

@@ src/skf_back.sv @@
module skf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  output logic              q_pop,
  input  skf_pkg::skf_cmd_t q_data,
  output logic              out_empty,
  input  logic              out_pop,
  output skf_pkg::skf_out_t out_data
);
  import skf_pkg::*;

  // per-channel filter state
  logic signed [EST_W-1:0] est_r [CHANNELS];
  logic [VAR_W-1:0]        var_r [CHANNELS];
  logic [VAR_W-1:0]        qn_r  [CHANNELS];
  logic [VAR_W-1:0]        rn_r  [CHANNELS];

  skf_state_t              state_r;
  skf_state_t              state_nxt;
  skf_cmd_t                cur_r;
  logic [VAR_W-1:0]        p_r;
  logic [SUM_W-1:0]        s_r;
  logic [SUM_W:0]          rem_r;
  logic [GAIN_W-1:0]       quo_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [GAIN_W-1:0]       gain_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [PE_W-1:0]  prod_e_r;
  logic [PP_W-1:0]         prod_p_r;
  skf_out_t                res_r;
  logic                    out_valid_r;
  skf_out_t                out_r;

  logic [CH_IDX_W-1:0]     idx;
  logic signed [EST_W-1:0] est_cur;
  logic [SUM_W-1:0]        p_sum;
  logic [VAR_W-1:0]        p_sat;
  logic [SUM_W-1:0]        s_sum;
  logic [SUM_W:0]          rem_shift;
  logic                    q_bit;
  logic [GAIN_W:0]         gain_comp;
  logic signed [PE_W-1:0]  rnd_e;
  logic signed [PE_W-1:0]  step_e;
  logic signed [EST_W-1:0] new_est;
  logic [PP_W-1:0]         rnd_p;
  logic [VAR_W-1:0]        new_var;
  logic                    out_load;

  assign idx       = cur_r.channel[CH_IDX_W-1:0];
  assign est_cur   = est_r[idx];
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_pop);
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  // predicted variance and gain denominator
  always_comb begin
    p_sum = {1'b0, var_r[idx]} + {1'b0, qn_r[idx]};
    p_sat = p_sum[SUM_W-1] ? {VAR_W{1'b1}} : p_sum[VAR_W-1:0];
    s_sum = {1'b0, p_sat} + {1'b0, rn_r[idx]};
  end

  // one restoring divider step
  always_comb begin
    rem_shift = {rem_r[SUM_W-1:0], 1'b0};
    q_bit     = (rem_shift >= {1'b0, s_r});
  end

  // rounded updates of estimate and variance
  always_comb begin
    gain_comp = (GAIN_W + 1)'(ONE_FX) - {1'b0, gain_r};
    rnd_e     = prod_e_r + PE_W'(ONE_FX >> 1);
    step_e    = rnd_e >>> FRAC_BITS;
    new_est   = est_cur + $signed(step_e[EST_W-1:0]);
    rnd_p     = prod_p_r + PP_W'(ONE_FX >> 1);
    new_var   = rnd_p[FRAC_BITS +: VAR_W];
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cur_r.op)
          OP_MEASURE: state_nxt = (rn_r[idx] == '0) ? ST_MUL : ST_DIV;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_pop) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          cur_r <= q_data;
        end
      end
      ST_EXEC: begin
        p_r    <= p_sat;
        s_r    <= s_sum;
        rem_r  <= {2'b00, p_sat};
        quo_r  <= '0;
        cnt_r  <= CNT_W'(GAIN_W - 1);
        diff_r <= {cur_r.measurement[EST_W-1], cur_r.measurement} - {est_cur[EST_W-1], est_cur};
        // gain is full scale when there is no measurement noise, zero if the predicted variance is zero
        gain_r <= (p_sat != '0) ? {GAIN_W{1'b1}} : '0;
        unique case (cur_r.op)
          OP_PASS: res_r <= '{estimate: cur_r.measurement, channel_echo: cur_r.channel,
                              passed_through: 1'b1};
          default: res_r <= '{estimate: est_cur, channel_echo: cur_r.channel,
                              passed_through: 1'b0};
        endcase
      end
      ST_DIV: begin
        rem_r  <= q_bit ? (rem_shift - {1'b0, s_r}) : rem_shift;
        quo_r  <= {quo_r[GAIN_W-2:0], q_bit};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          gain_r <= {quo_r[GAIN_W-2:0], q_bit};
        end
      end
      ST_MUL: begin
        prod_e_r <= $signed({1'b0, gain_r}) * diff_r;
        prod_p_r <= gain_comp * p_r;
      end
      ST_UPD: begin
        res_r <= '{estimate: new_est, channel_echo: cur_r.channel, passed_through: 1'b0};
      end
      default: begin
      end
    endcase
  end

  // channel state tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        est_r[i] <= EST_RESET;
        var_r[i] <= VAR_RESET;
        qn_r[i]  <= Q_RESET;
        rn_r[i]  <= R_RESET;
      end
    end else begin
      if ((state_r == ST_EXEC) && (cur_r.op == OP_SET)) begin
        qn_r[idx] <= cur_r.process_noise;
        rn_r[idx] <= cur_r.measurement_noise;
      end
      if (state_r == ST_UPD) begin
        est_r[idx] <= new_est;
        var_r[idx] <= new_var;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res_r;
    end
  end

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < {1'b0, s_r})
    else $error("divider remainder not below divisor");

  a_var_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> new_var <= p_r)
    else $error("variance grew on update");

  a_est_between: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |->
      ((diff_r >= 0) && (new_est >= est_cur) && (new_est <= cur_r.measurement)) ||
      ((diff_r < 0) && (new_est <= est_cur) && (new_est >= cur_r.measurement)))
    else $error("estimate left the span of estimate and measurement");

endmodule
